// File: design/dadd_pkg.sv
package dadd_pkg;

  localparam int unsigned DEF_MAX_YEAR    = 9999;
  localparam int unsigned DEF_OFFSET_BITS = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned YEAR_IN_W  = 14;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned OFF_W      = 17;
  localparam int unsigned MAG_W_MAX  = 17;
  localparam int unsigned Q100_W     = 8;
  localparam int unsigned R100_W     = 7;
  localparam int unsigned DOY_W      = 9;

  // year / 100 as (year * RECIP100) >> RECIP_SHIFT, exact for 14-bit years
  localparam int unsigned RECIP100    = 10486;
  localparam int unsigned RECIP_SHIFT = 20;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_YEAR,
    BK_MONTH,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [YEAR_IN_W-1:0] year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [R100_W-1:0]    r100;   // year mod 100
    logic [1:0]           c4;     // (year / 100) mod 4
    logic                 bad;
    logic                 neg;
    logic [MAG_W_MAX-1:0] mag;
  } item_t;

  function automatic logic leap_of(logic [1:0] ylo, logic [R100_W-1:0] r100, logic [1:0] c4);
    return (ylo == 2'd0) && ((r100 != '0) || (c4 == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [DOY_W-1:0] days_before_month(logic [MONTH_W-1:0] m, logic leap);
    logic [DOY_W-1:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

endpackage

// File: design/dadd_front.sv
module dadd_front import dadd_pkg::*; #(
  parameter int unsigned MAX_YEAR    = DEF_MAX_YEAR,
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [YEAR_IN_W-1:0]        in_start_year,
  input  logic [MONTH_W-1:0]          in_start_month,
  input  logic [DAY_W-1:0]            in_start_day,
  input  logic signed [OFF_W-1:0]     in_offset_days,
  output logic                        q_push,
  output item_t                       q_data,
  input  logic                        q_full
);

  localparam int unsigned YEAR_W = $clog2(MAX_YEAR + 1);
  localparam int unsigned MAG_W  = (OFFSET_BITS < MAG_W_MAX) ? OFFSET_BITS : MAG_W_MAX;
  localparam logic [MAG_W_MAX-1:0] MAG_LIM = MAG_W_MAX'((64'd1 << MAG_W) - 64'd1);

  logic                  vld_r, vld_nxt;
  logic [YEAR_IN_W-1:0]  year_r;
  logic [MONTH_W-1:0]    month_r;
  logic [DAY_W-1:0]      day_r;
  logic [OFF_W-1:0]      off_r;
  logic [Q100_W-1:0]     q100_r;

  logic [2*YEAR_IN_W-1:0] prod_w;
  logic [R100_W-1:0]      r100_w;
  logic                   leap_w;
  logic                   bad_w;
  logic [MAG_W_MAX-1:0]   mag_raw_w;

  assign in_stall = vld_r && q_full;
  assign q_push   = vld_r && !q_full;
  assign prod_w   = (2*YEAR_IN_W)'(in_start_year) * (2*YEAR_IN_W)'(RECIP100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      year_r  <= in_start_year;
      month_r <= in_start_month;
      day_r   <= in_start_day;
      off_r   <= in_offset_days;
      q100_r  <= Q100_W'(prod_w >> RECIP_SHIFT);
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && !in_stall) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end

    r100_w = R100_W'(year_r - (YEAR_IN_W'(q100_r) * YEAR_IN_W'(100)));
    leap_w = leap_of(year_r[1:0], r100_w, q100_r[1:0]);
    bad_w  = (year_r == '0) || (YEAR_W'(year_r) > YEAR_W'(MAX_YEAR)) ||
             (month_r == '0) || (month_r > 4'd12) ||
             (day_r == '0) || (day_r > month_days(month_r, leap_w));

    mag_raw_w = off_r[OFF_W-1] ? (MAG_W_MAX'(~off_r) + MAG_W_MAX'(1)) : MAG_W_MAX'(off_r);

    q_data.year  = year_r;
    q_data.month = month_r;
    q_data.day   = day_r;
    q_data.r100  = r100_w;
    q_data.c4    = q100_r[1:0];
    q_data.bad   = bad_w;
    q_data.neg   = off_r[OFF_W-1];
    q_data.mag   = (mag_raw_w > MAG_LIM) ? MAG_LIM : mag_raw_w;
  end

endmodule

// File: design/dadd_fifo.sv
module dadd_fifo import dadd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/dadd_back.sv
module dadd_back import dadd_pkg::*; #(
  parameter int unsigned MAX_YEAR = DEF_MAX_YEAR
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  item_t                q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [YEAR_IN_W-1:0] out_result_year,
  output logic [MONTH_W-1:0]   out_result_month,
  output logic [DAY_W-1:0]     out_result_day,
  output logic [1:0]           out_status
);

  localparam int unsigned YEAR_W = $clog2(MAX_YEAR + 1);

  back_state_t          state_r, state_nxt;
  logic [YEAR_W-1:0]    y_r, y_nxt;
  logic [R100_W-1:0]    r100_r, r100_nxt;
  logic [1:0]           c4_r, c4_nxt;
  logic [DOY_W-1:0]     doy_r, doy_nxt;
  logic [MAG_W_MAX-1:0] rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic [MONTH_W-1:0]   mon_r, mon_nxt;
  status_t              stat_r, stat_nxt;

  logic                 ov_r, ov_nxt;
  logic [YEAR_IN_W-1:0] oy_r, oy_nxt;
  logic [MONTH_W-1:0]   om_r, om_nxt;
  logic [DAY_W-1:0]     od_r, od_nxt;
  status_t              os_r, os_nxt;

  logic                 leap_h, leap_c, leap_p;
  logic [DOY_W-1:0]     ylast, left;
  logic [YEAR_W-1:0]    y_dec;
  logic [R100_W-1:0]    r100_dec;
  logic [1:0]           c4_dec;
  logic [DAY_W-1:0]     mdays;

  assign out_valid        = ov_r;
  assign out_result_year  = oy_r;
  assign out_result_month = om_r;
  assign out_result_day   = od_r;
  assign out_status       = os_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r    <= y_nxt;
    r100_r <= r100_nxt;
    c4_r   <= c4_nxt;
    doy_r  <= doy_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    mon_r  <= mon_nxt;
    stat_r <= stat_nxt;
    oy_r   <= oy_nxt;
    om_r   <= om_nxt;
    od_r   <= od_nxt;
    os_r   <= os_nxt;
  end

  always_comb begin
    leap_h   = leap_of(q_data.year[1:0], q_data.r100, q_data.c4);
    leap_c   = leap_of(y_r[1:0], r100_r, c4_r);
    ylast    = leap_c ? 9'd365 : 9'd364;
    left     = ylast - doy_r;
    y_dec    = y_r - YEAR_W'(1);
    r100_dec = (r100_r == '0) ? R100_W'(99) : r100_r - R100_W'(1);
    c4_dec   = (r100_r == '0) ? c4_r - 2'd1 : c4_r;
    leap_p   = leap_of(y_dec[1:0], r100_dec, c4_dec);
    mdays    = month_days(mon_r, leap_c);

    state_nxt = state_r;
    y_nxt     = y_r;
    r100_nxt  = r100_r;
    c4_nxt    = c4_r;
    doy_nxt   = doy_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    mon_nxt   = mon_r;
    stat_nxt  = stat_r;
    q_pop     = 1'b0;

    ov_nxt = ov_r && out_stall;
    oy_nxt = oy_r;
    om_nxt = om_r;
    od_nxt = od_r;
    os_nxt = os_r;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          y_nxt    = YEAR_W'(q_data.year);
          r100_nxt = q_data.r100;
          c4_nxt   = q_data.c4;
          neg_nxt  = q_data.neg;
          rem_nxt  = q_data.mag;
          mon_nxt  = 4'd1;
          doy_nxt  = days_before_month(q_data.month, leap_h) + DOY_W'(q_data.day) - 9'd1;
          if (q_data.bad) begin
            stat_nxt  = ST_BAD_START;
            state_nxt = BK_DONE;
          end else begin
            stat_nxt  = ST_OK;
            state_nxt = BK_YEAR;
          end
        end
      end
      BK_YEAR: begin
        if (!neg_r) begin
          if (rem_r <= MAG_W_MAX'(left)) begin
            doy_nxt   = doy_r + DOY_W'(rem_r);
            state_nxt = BK_MONTH;
          end else if (y_r == YEAR_W'(MAX_YEAR)) begin
            stat_nxt  = ST_RANGE;
            state_nxt = BK_DONE;
          end else begin
            rem_nxt  = rem_r - MAG_W_MAX'(left) - MAG_W_MAX'(1);
            doy_nxt  = '0;
            y_nxt    = y_r + YEAR_W'(1);
            r100_nxt = (r100_r == R100_W'(99)) ? '0 : r100_r + R100_W'(1);
            c4_nxt   = (r100_r == R100_W'(99)) ? c4_r + 2'd1 : c4_r;
          end
        end else begin
          if (rem_r <= MAG_W_MAX'(doy_r)) begin
            doy_nxt   = doy_r - DOY_W'(rem_r);
            state_nxt = BK_MONTH;
          end else if (y_r == YEAR_W'(1)) begin
            stat_nxt  = ST_RANGE;
            state_nxt = BK_DONE;
          end else begin
            rem_nxt  = rem_r - MAG_W_MAX'(doy_r) - MAG_W_MAX'(1);
            doy_nxt  = leap_p ? 9'd365 : 9'd364;
            y_nxt    = y_dec;
            r100_nxt = r100_dec;
            c4_nxt   = c4_dec;
          end
        end
      end
      BK_MONTH: begin
        if ((mon_r != 4'd12) && (doy_r >= DOY_W'(mdays))) begin
          doy_nxt = doy_r - DOY_W'(mdays);
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          os_nxt    = stat_r;
          state_nxt = BK_IDLE;
          if (stat_r == ST_OK) begin
            oy_nxt = YEAR_IN_W'(y_r);
            om_nxt = mon_r;
            od_nxt = DAY_W'(doy_r) + DAY_W'(1);
          end else begin
            oy_nxt = '0;
            om_nxt = '0;
            od_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

endmodule

// File: design/date_add_days_unit.sv
// Channel  Handshake            Word
// in       in_valid / in_stall  in_start_year, in_start_month, in_start_day, in_offset_days
// out      out_valid / out_stall out_result_year, out_result_month, out_result_day, out_status
//
// The back unit walks one year per cycle, then one month per cycle.
// Front register and a two-word queue take new words while the back unit works.
// rst_n is synchronous; it clears valids, queue pointers and the back state.
// out_stall holds the output register; the back unit waits and the queue fills behind it.
module date_add_days_unit import dadd_pkg::*; #(
  parameter int unsigned MAX_YEAR    = DEF_MAX_YEAR,
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [YEAR_IN_W-1:0]    in_start_year,
  input  logic [MONTH_W-1:0]      in_start_month,
  input  logic [DAY_W-1:0]        in_start_day,
  input  logic signed [OFF_W-1:0] in_offset_days,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [YEAR_IN_W-1:0]    out_result_year,
  output logic [MONTH_W-1:0]      out_result_month,
  output logic [DAY_W-1:0]        out_result_day,
  output logic [1:0]              out_status
);

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_wdata, q_rdata;

  dadd_front #(
    .MAX_YEAR    (MAX_YEAR),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_year  (in_start_year),
    .in_start_month (in_start_month),
    .in_start_day   (in_start_day),
    .in_offset_days (in_offset_days),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  dadd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dadd_back #(
    .MAX_YEAR (MAX_YEAR)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_data           (q_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status)
  );

endmodule
